@@ hw/rtl/fbd_pkg.sv @@
// Shared types and constants for the frame byte decoder.
// Used by fbd_front, fbd_queue, fbd_back and frame_byte_decoder; no dependencies.
package fbd_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [2:0] LONG_LEN  = 3'd7;
  localparam logic [2:0] LONG_LEFT = 3'd5;

  typedef enum logic [1:0] {
    CLS_DATA = 2'd0,
    CLS_END  = 2'd1,
    CLS_LEAD = 2'd2
  } byte_class_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_ADDR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_LEAD = 2'd1,
    ERR_END  = 2'd2,
    ERR_DATA = 2'd3
  } err_t;

  // Classified byte handed from front to back.
  typedef struct packed {
    byte_class_t cls;
    logic        is_cmd;
    logic        is_long;
    logic [2:0]  lead_left;
    logic [6:0]  bits;
  } item_t;

endpackage

@@ hw/rtl/fbd_front.sv @@
// Front end: classifies each received byte by its top bits and pre-decodes lead length.
// Depends on fbd_pkg.
module fbd_front (
  input  logic [7:0]     rx_byte,
  output fbd_pkg::item_t item
);

  logic [2:0] len;

  always_comb begin
    len = rx_byte[5:3];
    item.bits = rx_byte[6:0];
    if (rx_byte[7:6] == 2'b11) begin
      item.cls = fbd_pkg::CLS_LEAD;
    end else if (rx_byte[7:6] == 2'b10) begin
      item.cls = fbd_pkg::CLS_END;
    end else begin
      item.cls = fbd_pkg::CLS_DATA;
    end
    item.is_cmd  = (len <= 3'd1);
    item.is_long = (len == fbd_pkg::LONG_LEN);
    // bytes still expected after the lead, end byte included
    item.lead_left = item.is_long ? fbd_pkg::LONG_LEFT : (len - 3'd1);
  end

endmodule

@@ hw/rtl/fbd_queue.sv @@
// Short queue of classified words between front and back.
// Depends on fbd_pkg.
module fbd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fbd_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output fbd_pkg::item_t head
);

  fbd_pkg::item_t mem [fbd_pkg::QDEPTH];
  logic [fbd_pkg::QAW-1:0] wr_ptr;
  logic [fbd_pkg::QAW-1:0] rd_ptr;
  logic [fbd_pkg::QCW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full      = (count == fbd_pkg::QCW'(fbd_pkg::QDEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/fbd_back.sv @@
// Back end: frame state (bytes left, partial value) and the registered result word.
// Depends on fbd_pkg.
module fbd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  fbd_pkg::item_t item,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output fbd_pkg::kind_t kind,
  output logic [4:0]     command,
  output logic [6:0]     address,
  output logic [31:0]    data,
  output fbd_pkg::err_t  error
);

  logic [2:0]  bytes_left;
  logic [2:0]  bytes_left_next;
  logic [31:0] partial_value;
  logic [31:0] partial_value_next;

  fbd_pkg::kind_t kind_next;
  logic [4:0]     command_next;
  logic [6:0]     address_next;
  logic [31:0]    data_next;
  fbd_pkg::err_t  error_next;

  // take a word whenever the output register is free or being drained
  assign pop = item_valid && (!out_valid || out_ready);

  always_comb begin
    bytes_left_next    = bytes_left;
    partial_value_next = partial_value;
    kind_next          = fbd_pkg::KIND_NONE;
    command_next       = '0;
    address_next       = '0;
    data_next          = '0;
    error_next         = fbd_pkg::ERR_NONE;
    case (item.cls)
      fbd_pkg::CLS_LEAD: begin
        if (bytes_left != 3'd0) begin
          error_next = fbd_pkg::ERR_LEAD;
        end
        if (item.is_cmd) begin
          kind_next       = fbd_pkg::KIND_CMD;
          command_next    = {1'b0, item.bits[3:0]} + 5'd1;
          bytes_left_next = 3'd0;
        end else begin
          partial_value_next = item.is_long ? {28'd0, item.bits[3:0]}
                                            : {29'd0, item.bits[2:0]};
          bytes_left_next    = item.lead_left;
        end
      end
      fbd_pkg::CLS_END: begin
        if (bytes_left == 3'd1) begin
          kind_next    = fbd_pkg::KIND_ADDR;
          address_next = {1'b0, item.bits[5:0]} + 7'd1;
          data_next    = partial_value;
        end else begin
          error_next = fbd_pkg::ERR_END;
        end
        bytes_left_next = 3'd0;
      end
      fbd_pkg::CLS_DATA: begin
        if (bytes_left < 3'd2) begin
          error_next      = fbd_pkg::ERR_DATA;
          bytes_left_next = 3'd0;
        end else begin
          // shift in 7 bits MSB first, drop what falls off the top
          partial_value_next = {partial_value[24:0], item.bits};
          bytes_left_next    = bytes_left - 3'd1;
        end
      end
      default: begin
        bytes_left_next = bytes_left;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= '0;
      partial_value <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        bytes_left    <= bytes_left_next;
        partial_value <= partial_value_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind    <= kind_next;
      command <= command_next;
      address <= address_next;
      data    <= data_next;
      error   <= error_next;
    end
  end

endmodule

@@ hw/rtl/frame_byte_decoder.sv @@
// Frame byte decoder: one received byte per input word, one result word per byte, in order.
// Sustains one byte per clock while the output is not stalled; a byte's result passes
// through the queue and then the back end's output register before it is offered. The
// rate is set by the back end's update of bytes_left and partial_value; a four-word
// queue lets input keep flowing while output stalls.
// Depends on fbd_pkg, fbd_front, fbd_queue, fbd_back.
module frame_byte_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [4:0] command, [11:5] address, [43:12] data,
                                 // [45:44] error, [47:46] zero
  output logic [1:0]  m_tuser    // [1:0] kind
);

  fbd_pkg::item_t front_item;
  fbd_pkg::item_t head_item;
  logic           q_full;
  logic           q_not_empty;
  logic           q_pop;

  fbd_pkg::kind_t kind;
  logic [4:0]     command;
  logic [6:0]     address;
  logic [31:0]    data;
  fbd_pkg::err_t  error;

  fbd_front u_front (
    .rx_byte (s_tdata),
    .item    (front_item)
  );

  fbd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_item)
  );

  fbd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_not_empty),
    .item       (head_item),
    .pop        (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .kind       (kind),
    .command    (command),
    .address    (address),
    .data       (data),
    .error      (error)
  );

  assign s_tready = !q_full;
  assign m_tuser  = kind;
  assign m_tdata  = {2'b00, error, data, address, command};

  a_cmd_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == fbd_pkg::KIND_CMD) |->
      (m_tdata[4:0] != 5'd0 && m_tdata[11:5] == 7'd0 && m_tdata[43:12] == 32'd0))
    else $error("command result with bad fields");

  a_addr_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == fbd_pkg::KIND_ADDR) |->
      (m_tdata[45:44] == fbd_pkg::ERR_NONE && m_tdata[11:5] != 7'd0
       && m_tdata[4:0] == 5'd0))
    else $error("address result with error or bad fields");

  a_err_no_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[45:44] == fbd_pkg::ERR_END || m_tdata[45:44] == fbd_pkg::ERR_DATA))
      |-> (m_tuser == fbd_pkg::KIND_NONE))
    else $error("end or data error reported with a decoded kind");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == fbd_pkg::KIND_NONE) |-> (m_tdata[43:0] == 44'd0))
    else $error("empty result carries payload");

endmodule
